@@ rtl/core/rc5_pkg.sv @@
// ----------------------------------------------------------------------------
// rc5_pkg
// Shared constants, types and word functions of the RC5-16/12/16 cipher core.
// ----------------------------------------------------------------------------
`default_nettype none

package rc5_pkg;

   localparam int WORD_W    = 16;
   localparam int ROT_W     = $clog2(WORD_W);
   localparam int ROUNDS    = 12;
   localparam int CELLS     = ROUNDS + 1;        // one round-key pair per cell
   localparam int KEY_WORDS = 8;
   localparam int KEY_W     = 64;
   localparam int EXP_PAIRS = 3 * CELLS;         // 3 laps of the round-key ring
   localparam int PAIR_W    = $clog2(EXP_PAIRS);
   localparam int STEP_W    = $clog2(ROUNDS + 1);
   localparam int ADDR_W    = 4;

   localparam logic [WORD_W-1:0] MAGIC_P = 16'hb7e1;
   localparam logic [WORD_W-1:0] MAGIC_Q = 16'h9e37;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   localparam logic REG_KEY_LOW  = 1'b0;
   localparam logic REG_KEY_HIGH = 1'b1;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      word_type odd;
      word_type even;
   } pair_type;

   typedef enum logic [1:0] {
      CELL_HOLD = 2'd0,
      CELL_LOAD = 2'd1,
      CELL_FWD  = 2'd2,
      CELL_BWD  = 2'd3
   } cell_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EXPAND = 3'b010,
      ST_CRYPT  = 3'b100
   } state_type;

   function automatic word_type rotl(input word_type x, input logic [ROT_W-1:0] amt);
      logic [2*WORD_W-1:0] d;
      d = {x, x} << amt;
      return d[2*WORD_W-1:WORD_W];
   endfunction

   function automatic word_type rotr(input word_type x, input logic [ROT_W-1:0] amt);
      logic [2*WORD_W-1:0] d;
      d = {x, x} >> amt;
      return d[WORD_W-1:0];
   endfunction

   // initial round-key word P + i*Q
   function automatic word_type init_word(input int idx);
      logic [31:0] v;
      v = 32'(MAGIC_P) + 32'(idx) * 32'(MAGIC_Q);
      return v[WORD_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/rc5_if.sv @@
// ----------------------------------------------------------------------------
// rc5_if
// Valid/ready stream interfaces for the cipher's block and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface rc5_req_if;
   import rc5_pkg::*;
   logic       valid;
   logic       ready;
   logic       opcode;
   word_type   word_a;
   word_type   word_b;

   modport source (output valid, output opcode, output word_a, output word_b,
                   input ready);
   modport sink   (input valid, input opcode, input word_a, input word_b,
                   output ready);
endinterface

interface rc5_rsp_if;
   import rc5_pkg::*;
   logic       valid;
   logic       ready;
   word_type   result_a;
   word_type   result_b;

   modport source (output valid, output result_a, output result_b, input ready);
   modport sink   (input valid, input result_a, input result_b, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rc5_16_block_cipher.sv @@
// ----------------------------------------------------------------------------
// rc5_16_block_cipher
// RC5 with 16-bit words, 12 rounds and a 128-bit key, one block at a time.
// ----------------------------------------------------------------------------
// Use: the key is written through the APB-style port (key_low at 0x0,
// key_high at 0x8, 64-bit data, paddr[3] selects the register, pready is
// always high). Blocks arrive on req (opcode 0 encrypt, 1 decrypt, word_a,
// word_b) and results leave on rsp (result_a, result_b), both valid/ready.
// Round keys live in a ring of 13 cells, one key pair each. The ring turns
// one cell a cycle while a block advances, forward for encryption and
// backward for decryption, so the round datapath always reads a fixed cell.
// One round per cycle on the single round datapath, held at the last round
// for rsp; with the key expanded, the accept edge does the whitening step.
// The first block after reset or after any key write first runs the key
// schedule, one mixing step a cycle over the ring, and then its whitening
// step and rounds. Reset clears the key registers to zero, drops the
// expanded flag and empties the result register.
// The result sits in an output register; a new block is accepted while it
// waits. If it is still untaken when the next block finishes, the core
// holds on its last round until rsp is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rc5_16_block_cipher
   import rc5_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   rc5_req_if.sink                 req,
   rc5_rsp_if.source               rsp,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [ADDR_W-1:0]  paddr,
   input  wire logic [KEY_W-1:0]   pwdata,
   output logic [KEY_W-1:0]        prdata,
   output logic                    pready
);

   // configuration
   logic [KEY_W-1:0] key_low_ff, key_high_ff;
   logic             cfg_write;
   logic             cfg_sel;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;
   assign cfg_sel   = paddr[3];
   assign prdata    = (cfg_sel == REG_KEY_HIGH) ? key_high_ff : key_low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (cfg_write) begin
         if (cfg_sel == REG_KEY_HIGH) begin
            key_high_ff <= pwdata;
         end else begin
            key_low_ff <= pwdata;
         end
      end
   end

   // control state
   state_type               state_ff, state_in;
   logic                    expanded_ff, expanded_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [PAIR_W-1:0]       pair_cnt_ff, pair_cnt_in;
   logic                    phase_ff, phase_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // payload
   logic                    op_ff, op_in;
   word_type                da_ff, da_in, db_ff, db_in;
   word_type                ka_ff, ka_in, kb_ff, kb_in;
   word_type                ra_ff, ra_in, rb_ff, rb_in;

   logic                    accept, is_idle, is_expand, is_crypt;
   logic                    first_step, last_step, out_free, advance, exp_done;

   // rings
   pair_type                s_pair [CELLS];
   word_type                l_word [KEY_WORDS];
   cell_mode_type           s_mode, l_mode;
   pair_type                wrap_pair;
   pair_type                head, tail, kp;

   // round datapath
   logic                    cur_op;
   word_type                cur_a, cur_b, enc_a, enc_b, dec_a, dec_b, new_a, new_b;
   word_type                mix_t, ka_new, sum2, kb_new, sk;

   assign is_idle   = (state_ff == ST_IDLE);
   assign is_expand = (state_ff == ST_EXPAND);
   assign is_crypt  = (state_ff == ST_CRYPT);
   assign req.ready = is_idle;
   assign accept    = req.valid & is_idle;

   assign first_step = (step_ff == '0);
   assign last_step  = (step_ff == STEP_W'(ROUNDS));
   assign out_free   = ~rsp_valid_ff | rsp.ready;
   assign advance    = (is_idle & accept & expanded_ff) |
                       (is_crypt & (~last_step | out_free));
   assign exp_done   = is_expand & phase_ff & (pair_cnt_ff == PAIR_W'(EXP_PAIRS - 1));

   assign head = s_pair[0];
   assign tail = s_pair[CELLS-1];

   // ---------------------------------------------------------------- rounds
   assign cur_op = is_idle ? req.opcode : op_ff;
   assign cur_a  = is_idle ? req.word_a : da_ff;
   assign cur_b  = is_idle ? req.word_b : db_ff;
   assign kp     = (cur_op == OP_DECRYPT) ? tail : head;

   always_comb begin
      word_type t;
      t = '0;
      // encryption: whitening on the first step, then one round a step
      if (first_step) begin
         enc_a = cur_a + kp.even;
         enc_b = cur_b + kp.odd;
      end else begin
         enc_a = rotl(cur_a ^ cur_b, cur_b[ROT_W-1:0]) + kp.even;
         enc_b = rotl(cur_b ^ enc_a, enc_a[ROT_W-1:0]) + kp.odd;
      end
      // decryption: rounds from the top, whitening removed on the last step
      if (last_step) begin
         dec_b = cur_b - kp.odd;
         dec_a = cur_a - kp.even;
      end else begin
         t     = cur_b - kp.odd;
         dec_b = rotr(t, cur_a[ROT_W-1:0]) ^ cur_a;
         t     = cur_a - kp.even;
         dec_a = rotr(t, dec_b[ROT_W-1:0]) ^ dec_b;
      end
      new_a = (cur_op == OP_DECRYPT) ? dec_a : enc_a;
      new_b = (cur_op == OP_DECRYPT) ? dec_b : enc_b;
   end

   // ---------------------------------------------------------- key schedule
   assign sk     = phase_ff ? head.odd : head.even;
   assign mix_t  = sk + ka_ff + kb_ff;
   assign ka_new = rotl(mix_t, ROT_W'(3));
   assign sum2   = ka_new + kb_ff;
   assign kb_new = rotl(l_word[0] + sum2, sum2[ROT_W-1:0]);

   // the mixed pair re-enters the ring at the far end
   always_comb begin
      wrap_pair = head;
      if (is_expand) begin
         wrap_pair.even = ka_ff;
         wrap_pair.odd  = ka_new;
      end
   end

   always_comb begin
      s_mode = CELL_HOLD;
      l_mode = CELL_HOLD;
      if (is_idle & accept & ~expanded_ff) begin
         s_mode = CELL_LOAD;
         l_mode = CELL_LOAD;
      end else if (is_expand) begin
         l_mode = CELL_FWD;
         if (phase_ff) begin
            s_mode = CELL_FWD;
         end
      end else if (advance) begin
         s_mode = (cur_op == OP_DECRYPT) ? CELL_BWD : CELL_FWD;
      end
   end

   for (genvar i = 0; i < CELLS; i++) begin : g_scell
      pair_type load_p, next_p;
      assign load_p.even = init_word(2 * i);
      assign load_p.odd  = init_word(2 * i + 1);
      if (i == CELLS - 1) begin : g_end
         assign next_p = wrap_pair;
      end else begin : g_mid
         assign next_p = s_pair[i+1];
      end
      rc5_cell u_cell (
         .clock     (clock),
         .mode      (s_mode),
         .load_pair (load_p),
         .next_pair (next_p),
         .prev_pair (s_pair[(i + CELLS - 1) % CELLS]),
         .pair      (s_pair[i])
      );
   end

   for (genvar j = 0; j < KEY_WORDS; j++) begin : g_kcell
      word_type load_w, next_w;
      if (j < KEY_WORDS / 2) begin : g_lo
         assign load_w = key_low_ff[WORD_W*j +: WORD_W];
      end else begin : g_hi
         assign load_w = key_high_ff[WORD_W*(j - KEY_WORDS/2) +: WORD_W];
      end
      if (j == KEY_WORDS - 1) begin : g_end
         assign next_w = kb_new;
      end else begin : g_mid
         assign next_w = l_word[j+1];
      end
      rc5_kcell u_kcell (
         .clock     (clock),
         .mode      (l_mode),
         .load_word (load_w),
         .next_word (next_w),
         .kword     (l_word[j])
      );
   end

   // ----------------------------------------------------------- sequencing
   always_comb begin
      state_in     = state_ff;
      expanded_in  = expanded_ff;
      step_in      = step_ff;
      pair_cnt_in  = pair_cnt_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      op_in        = op_ff;
      da_in        = da_ff;
      db_in        = db_ff;
      ka_in        = ka_ff;
      kb_in        = kb_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in = req.opcode;
               if (expanded_ff) begin
                  da_in    = new_a;
                  db_in    = new_b;
                  step_in  = STEP_W'(1);
                  state_in = ST_CRYPT;
               end else begin
                  da_in       = req.word_a;
                  db_in       = req.word_b;
                  ka_in       = '0;
                  kb_in       = '0;
                  pair_cnt_in = '0;
                  phase_in    = 1'b0;
                  state_in    = ST_EXPAND;
               end
            end
         end
         ST_EXPAND: begin
            ka_in    = ka_new;
            kb_in    = kb_new;
            phase_in = ~phase_ff;
            if (phase_ff) begin
               pair_cnt_in = pair_cnt_ff + PAIR_W'(1);
            end
            if (exp_done) begin
               expanded_in = 1'b1;
               step_in     = '0;
               state_in    = ST_CRYPT;
            end
         end
         ST_CRYPT: begin
            if (advance) begin
               if (last_step) begin
                  ra_in        = new_a;
                  rb_in        = new_b;
                  rsp_valid_in = 1'b1;
                  step_in      = '0;
                  state_in     = ST_IDLE;
               end else begin
                  da_in   = new_a;
                  db_in   = new_b;
                  step_in = step_ff + STEP_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg_write) begin
         expanded_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         expanded_ff  <= 1'b0;
         step_ff      <= '0;
         pair_cnt_ff  <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         expanded_ff  <= expanded_in;
         step_ff      <= step_in;
         pair_cnt_ff  <= pair_cnt_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      da_ff <= da_in;
      db_ff <= db_in;
      ka_ff <= ka_in;
      kb_ff <= kb_in;
      ra_ff <= ra_in;
      rb_ff <= rb_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.result_a = ra_ff;
   assign rsp.result_b = rb_ff;

endmodule

`default_nettype wire

@@ rtl/core/rc5_cell.sv @@
// ----------------------------------------------------------------------------
// rc5_cell
// One cell of the round-key ring: holds a pair of round keys and takes its
// neighbour's pair when the ring turns forward or backward.
// ----------------------------------------------------------------------------
`default_nettype none

module rc5_cell
   import rc5_pkg::*;
(
   input  wire logic          clock,
   input  wire cell_mode_type mode,
   input  wire pair_type      load_pair,
   input  wire pair_type      next_pair,
   input  wire pair_type      prev_pair,
   output pair_type           pair
);

   pair_type pair_ff, pair_in;

   always_comb begin
      unique case (mode)
         CELL_LOAD: pair_in = load_pair;
         CELL_FWD:  pair_in = next_pair;
         CELL_BWD:  pair_in = prev_pair;
         default:   pair_in = pair_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
   end

   assign pair = pair_ff;

endmodule

`default_nettype wire

@@ rtl/core/rc5_kcell.sv @@
// ----------------------------------------------------------------------------
// rc5_kcell
// One cell of the key-word ring used by the key schedule: holds one key word
// and takes its neighbour's word at every mixing step.
// ----------------------------------------------------------------------------
`default_nettype none

module rc5_kcell
   import rc5_pkg::*;
(
   input  wire logic          clock,
   input  wire cell_mode_type mode,
   input  wire word_type      load_word,
   input  wire word_type      next_word,
   output word_type           kword
);

   word_type word_ff, word_in;

   always_comb begin
      unique case (mode)
         CELL_LOAD: word_in = load_word;
         CELL_FWD:  word_in = next_word;
         default:   word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign kword = word_ff;

endmodule

`default_nettype wire
